// File: hw/rtl/mms_pkg.sv
// ----------------------------------------------------------------------------
// mms_pkg
// Shared widths, codes and record types of the min/max stack.
// ----------------------------------------------------------------------------
package mms_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int VALUE_BITS  = 32;
   localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
   localparam int COUNT_BITS  = $clog2(STACK_DEPTH + 1);

   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(STACK_DEPTH);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } err_type;

   // one stack entry: the value and the running extremes down to the bottom
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic signed [VALUE_BITS-1:0] min_v;
      logic signed [VALUE_BITS-1:0] max_v;
   } entry_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      entry_type             wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] top_value;
      logic signed [VALUE_BITS-1:0] min_value;
      logic signed [VALUE_BITS-1:0] max_value;
      logic                         is_empty;
      logic [COUNT_BITS-1:0]        depth;
      err_type                      error;
   } rsp_type;

endpackage

// File: hw/rtl/min_max_stack.sv
// A push or a failed op writes its result beat into the result buffer at
// accept; a pop that leaves entries writes it once the new top has been read
// back from the entry memory. Pushes are taken one per cycle while the result
// buffer is not full; a pop that leaves entries stalls the next request.
// Reset (synchronous, active high) empties the stack and the result buffer;
// the entry memory is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
// min_max_stack
// LIFO stack of signed values that reports top, minimum and maximum after
// every push or pop.
// ----------------------------------------------------------------------------
module min_max_stack
   import mms_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [VALUE_BITS-1:0] rsp_top_value,
   output logic signed [VALUE_BITS-1:0] rsp_min_value,
   output logic signed [VALUE_BITS-1:0] rsp_max_value,
   output logic                         rsp_is_empty,
   output logic [COUNT_BITS-1:0]        rsp_depth,
   output logic [1:0]                   rsp_error
);

   mem_req_type mem_req;
   entry_type   rd_data;
   logic        res_full;
   logic        res_valid;
   rsp_type     res_data;
   rsp_type     out_data;

   mms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_value (req_value),
      .mem_req   (mem_req),
      .rd_data   (rd_data),
      .res_full  (res_full),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   mms_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   mms_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .full      (res_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_top_value = out_data.top_value;
   assign rsp_min_value = out_data.min_value;
   assign rsp_max_value = out_data.max_value;
   assign rsp_is_empty  = out_data.is_empty;
   assign rsp_depth     = out_data.depth;
   assign rsp_error     = out_data.error;

endmodule

// File: hw/rtl/mms_mem.sv
// ----------------------------------------------------------------------------
// mms_mem
// Entry memory of the stack: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mms_mem
   import mms_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rd_data
);

   entry_type store [STACK_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         store[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= store[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mms_rsp_fifo.sv
// ----------------------------------------------------------------------------
// mms_rsp_fifo
// Two-beat result buffer: an output register plus a skid register, so the
// stack keeps taking requests while one result waits downstream.
// ----------------------------------------------------------------------------
module mms_rsp_fifo
   import mms_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic [1:0] occ_ff, occ_in;
   rsp_type    head_ff, head_in;
   rsp_type    skid_ff, skid_in;
   logic       out_pop;

   always_comb begin
      out_pop = (occ_ff != 2'd0) && !out_stall;
      occ_in  = occ_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (out_pop) begin
         // advance the skid beat into the output register
         head_in = skid_ff;
         occ_in  = occ_in - 2'd1;
      end
      if (in_valid) begin
         if (occ_in == 2'd0) begin
            head_in = in_data;
         end else begin
            skid_in = in_data;
         end
         occ_in = occ_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 2'd0;
      end else begin
         occ_ff <= occ_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign full      = (occ_ff == 2'd2);
   assign out_valid = (occ_ff != 2'd0);
   assign out_data  = head_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(in_valid && (occ_ff == 2'd2) && !out_pop))
      else $error("result buffer overrun");

endmodule

// File: hw/rtl/mms_ctrl.sv
// ----------------------------------------------------------------------------
// mms_ctrl
// Stack control: keeps the count and a copy of the top entry, writes pushes
// to the entry memory and refetches the new top after a pop.
// ----------------------------------------------------------------------------
module mms_ctrl
   import mms_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic signed [VALUE_BITS-1:0] req_value,
   output mem_req_type                  mem_req,
   input  entry_type                    rd_data,
   input  logic                         res_full,
   output logic                         res_valid,
   output rsp_type                      res_data
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   entry_type             top_ff, top_in;
   logic                  busy_ff, busy_in;
   logic                  accept;
   err_type               err;
   logic [COUNT_BITS-1:0] below;
   entry_type             pushed;

   assign req_stall = busy_ff || res_full;
   assign accept    = req_valid && !req_stall;
   assign below     = count_ff - COUNT_BITS'(2);

   always_comb begin
      pushed.value = req_value;
      pushed.min_v = req_value;
      pushed.max_v = req_value;
      if (count_ff != '0) begin
         if ($signed(top_ff.min_v) < $signed(req_value)) begin
            pushed.min_v = top_ff.min_v;
         end
         if ($signed(req_value) < $signed(top_ff.max_v)) begin
            pushed.max_v = top_ff.max_v;
         end
      end
   end

   always_comb begin
      count_in  = count_ff;
      top_in    = top_ff;
      busy_in   = 1'b0;
      err       = ERR_OK;
      res_valid = 1'b0;
      mem_req   = '0;
      if (busy_ff) begin
         // refetched entry below the popped one becomes the top
         top_in    = rd_data;
         res_valid = 1'b1;
      end else if (accept) begin
         res_valid = 1'b1;
         unique case (req_op)
            OP_PUSH: begin
               if (count_ff == COUNT_FULL) begin
                  err = ERR_OVERFLOW;
               end else begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_addr = count_ff[ADDR_BITS-1:0];
                  mem_req.wr_data = pushed;
                  top_in          = pushed;
                  count_in        = count_ff + COUNT_BITS'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  err = ERR_UNDERFLOW;
               end else begin
                  count_in = count_ff - COUNT_BITS'(1);
                  if (count_ff != COUNT_BITS'(1)) begin
                     // hold the result until the new top is read back
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = below[ADDR_BITS-1:0];
                     busy_in         = 1'b1;
                     res_valid       = 1'b0;
                  end
               end
            end
            default: begin
               err = ERR_OK;
            end
         endcase
      end
   end

   always_comb begin
      res_data.depth    = count_in;
      res_data.is_empty = (count_in == '0);
      res_data.error    = err;
      if (count_in == '0) begin
         res_data.top_value = '1;
         res_data.min_value = '1;
         res_data.max_value = '1;
      end else begin
         res_data.top_value = top_in.value;
         res_data.min_value = top_in.min_v;
         res_data.max_value = top_in.max_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
      end
      top_ff <= top_in;
   end

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("pop refetch lasted more than one cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_FULL)
      else $error("entry count beyond capacity");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_PUSH) && (count_ff != COUNT_FULL))
      |=> (count_ff == $past(count_ff) + COUNT_BITS'(1)))
      else $error("push did not grow the stack");

endmodule

// File: bench/tb_min_max_stack.sv
// ----------------------------------------------------------------------------
// tb_min_max_stack
// Self-checking bench for the min/max stack. Push and pop beats are sent in
// bursts. A local model of the stack works out the top, minimum, maximum,
// depth and error for each beat, and every result beat is checked against
// that model. Pops on an empty stack, pushes on a full stack and runs of
// equal values are sent on purpose.
// ----------------------------------------------------------------------------
module tb_min_max_stack;
   import mms_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      logic                         op;
      logic signed [VALUE_BITS-1:0] value;
   } stack_cmd_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_op = OP_PUSH;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_top_value;
   logic signed [VALUE_BITS-1:0] rsp_min_value;
   logic signed [VALUE_BITS-1:0] rsp_max_value;
   logic                         rsp_is_empty;
   logic [COUNT_BITS-1:0]        rsp_depth;
   logic [1:0]                   rsp_error;

   stack_cmd_type pending_cmds[$];
   rsp_type       expected_rsp[$];

   // model of the stack contents
   logic signed [VALUE_BITS-1:0] stack_vals [STACK_DEPTH];
   logic signed [VALUE_BITS-1:0] stack_mins [STACK_DEPTH];
   logic signed [VALUE_BITS-1:0] stack_maxs [STACK_DEPTH];
   int stack_count = 0;

   int  fill_depth = 0;
   int  gap_left = 0;
   int  burst_left = 0;
   int  rcv_cycle = 0;
   int  cycle_count = 0;
   int  mismatches = 0;
   bit  took_beat;

   min_max_stack u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_top_value (rsp_top_value),
      .rsp_min_value (rsp_min_value),
      .rsp_max_value (rsp_max_value),
      .rsp_is_empty  (rsp_is_empty),
      .rsp_depth     (rsp_depth),
      .rsp_error     (rsp_error)
   );

   always #1 clock = ~clock;

   function automatic rsp_type step_stack(logic op, logic signed [VALUE_BITS-1:0] v);
      rsp_type                      r;
      logic signed [VALUE_BITS-1:0] lo;
      logic signed [VALUE_BITS-1:0] hi;
      r.error = ERR_OK;
      if (op == OP_PUSH) begin
         if (stack_count >= STACK_DEPTH) begin
            r.error = ERR_OVERFLOW;
         end else begin
            lo = v;
            hi = v;
            if (stack_count > 0) begin
               if (stack_mins[stack_count-1] < lo) lo = stack_mins[stack_count-1];
               if (stack_maxs[stack_count-1] > hi) hi = stack_maxs[stack_count-1];
            end
            stack_vals[stack_count] = v;
            stack_mins[stack_count] = lo;
            stack_maxs[stack_count] = hi;
            stack_count++;
         end
      end else if (stack_count == 0) begin
         r.error = ERR_UNDERFLOW;
      end else begin
         stack_count--;
      end
      if (stack_count == 0) begin
         r.top_value = -1;
         r.min_value = -1;
         r.max_value = -1;
         r.is_empty  = 1'b1;
      end else begin
         r.top_value = stack_vals[stack_count-1];
         r.min_value = stack_mins[stack_count-1];
         r.max_value = stack_maxs[stack_count-1];
         r.is_empty  = 1'b0;
      end
      r.depth = COUNT_BITS'(stack_count);
      return r;
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b0, {(VALUE_BITS-1){1'b1}}};
         1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
         2: return $urandom_range(0, 1) ? '0 : '1;
         3, 4: return VALUE_BITS'($signed($urandom_range(0, 40)) - 20);
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   // track the expected depth so that fill and drain runs land on the edges
   task automatic queue_cmd(logic op, logic signed [VALUE_BITS-1:0] v);
      stack_cmd_type c;
      c.op    = op;
      c.value = v;
      pending_cmds = {pending_cmds, c};
      if (op == OP_PUSH && fill_depth < STACK_DEPTH) fill_depth++;
      if (op == OP_POP && fill_depth > 0) fill_depth--;
   endtask

   task automatic report(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // stimulus and end of run
   initial begin : stimulus
      int                           issued;
      int                           run_len;
      int                           push_pct;
      logic signed [VALUE_BITS-1:0] v;

      // underflow first, then the value extremes and equal entries
      queue_cmd(OP_POP, '1);
      queue_cmd(OP_PUSH, {1'b0, {(VALUE_BITS-1){1'b1}}});
      queue_cmd(OP_PUSH, {1'b1, {(VALUE_BITS-1){1'b0}}});
      queue_cmd(OP_PUSH, '0);
      queue_cmd(OP_PUSH, '1);
      queue_cmd(OP_PUSH, '1);
      queue_cmd(OP_PUSH, 32'sd5);
      queue_cmd(OP_POP, 32'h5a5a_a5a5);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_PUSH, 32'sd7);
      queue_cmd(OP_PUSH, 32'sd7);
      repeat (7) queue_cmd(OP_POP, '1);
      queue_cmd(OP_POP, '0);
      queue_cmd(OP_PUSH, 32'sd3);
      queue_cmd(OP_POP, '0);

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            5: begin
               // fill to capacity and push past it
               run_len = STACK_DEPTH - fill_depth + $urandom_range(1, 3);
               repeat (run_len) queue_cmd(OP_PUSH, pick_value());
            end
            6: begin
               run_len = fill_depth + $urandom_range(1, 2);
               repeat (run_len) queue_cmd(OP_POP, VALUE_BITS'($urandom));
            end
            7: begin
               run_len = $urandom_range(3, 8);
               v = pick_value();
               repeat (run_len) queue_cmd(OP_PUSH, v);
            end
            8: begin
               run_len = $urandom_range(4, 16);
               repeat (run_len) begin
                  queue_cmd(1'($urandom_range(0, 1)), pick_value());
               end
            end
            default: begin
               run_len  = $urandom_range(10, 40);
               push_pct = $urandom_range(30, 80);
               repeat (run_len) begin
                  if ($urandom_range(1, 100) <= push_pct)
                     queue_cmd(OP_PUSH, pick_value());
                  else
                     queue_cmd(OP_POP, VALUE_BITS'($urandom));
               end
            end
         endcase
         issued += run_len;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      // drain window for stray result beats
      repeat (6) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // request driver: bursts of beats with random gaps between them
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         took_beat = req_valid && !req_stall;
         if (took_beat) begin
            expected_rsp = {expected_rsp, step_stack(req_op, req_value)};
            void'(pending_cmds.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         // hold a stalled beat, otherwise advance
         if (!req_valid || took_beat) begin
            if (gap_left > 0 || pending_cmds.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_op    <= pending_cmds[0].op;
               req_value <= pending_cmds[0].value;
            end
         end
      end
   end

   // result monitor and stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: result beat expected none, actual depth %0d", $time,
                        rsp_depth);
               mismatches++;
            end else begin
               report("top_value", expected_rsp[0].top_value, rsp_top_value);
               report("min_value", expected_rsp[0].min_value, rsp_min_value);
               report("max_value", expected_rsp[0].max_value, rsp_max_value);
               report("is_empty", expected_rsp[0].is_empty, rsp_is_empty);
               report("depth", expected_rsp[0].depth, rsp_depth);
               report("error", expected_rsp[0].error, rsp_error);
               void'(expected_rsp.pop_front());
            end
         end
         rcv_cycle++;
         // rotate through stall modes, one of them with no stalls at all
         case ((rcv_cycle / 150) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ((rcv_cycle % 7) < 3);
            default: rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
